>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sgs_pkg.sv
package sgs_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int DEPTH        = 9;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = 4;
	localparam int HALF_W       = 3;

	// datapath widths
	localparam int TERM_W = SAMPLE_WIDTH + 7;
	localparam int SUM_W  = SAMPLE_WIDTH + 10;
	localparam int ACC_W  = SAMPLE_WIDTH + 12;
	localparam int A_W    = SAMPLE_WIDTH + 9;
	localparam int MUL_W  = A_W + 1;
	localparam int PROD_W = A_W + MUL_W;

	typedef enum logic [1:0] {
		WIN_5 = 2'd0,
		WIN_7 = 2'd1,
		WIN_9 = 2'd2
	} win_t;

	localparam int DIV_5 = 35;
	localparam int DIV_7 = 21;
	localparam int DIV_9 = 231;

	// reciprocal of 2*div, exact for numerators below 2**A_W
	localparam int SHIFT_5 = A_W + $clog2(2 * DIV_5);
	localparam int SHIFT_7 = A_W + $clog2(2 * DIV_7);
	localparam int SHIFT_9 = A_W + $clog2(2 * DIV_9);
	localparam longint unsigned RECIP_5 =
		((64'd1 << SHIFT_5) + 64'(2 * DIV_5) - 64'd1) / 64'(2 * DIV_5);
	localparam longint unsigned RECIP_7 =
		((64'd1 << SHIFT_7) + 64'(2 * DIV_7) - 64'd1) / 64'(2 * DIV_7);
	localparam longint unsigned RECIP_9 =
		((64'd1 << SHIFT_9) + 64'(2 * DIV_9) - 64'd1) / 64'(2 * DIV_9);

	localparam logic signed [TERM_W-1:0] WT5_0 = TERM_W'(17);
	localparam logic signed [TERM_W-1:0] WT5_1 = TERM_W'(12);
	localparam logic signed [TERM_W-1:0] WT5_2 = TERM_W'(-3);
	localparam logic signed [TERM_W-1:0] WT7_0 = TERM_W'(7);
	localparam logic signed [TERM_W-1:0] WT7_1 = TERM_W'(6);
	localparam logic signed [TERM_W-1:0] WT7_2 = TERM_W'(3);
	localparam logic signed [TERM_W-1:0] WT7_3 = TERM_W'(-2);
	localparam logic signed [TERM_W-1:0] WT9_0 = TERM_W'(59);
	localparam logic signed [TERM_W-1:0] WT9_1 = TERM_W'(54);
	localparam logic signed [TERM_W-1:0] WT9_2 = TERM_W'(39);
	localparam logic signed [TERM_W-1:0] WT9_3 = TERM_W'(14);
	localparam logic signed [TERM_W-1:0] WT9_4 = TERM_W'(-21);

	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_in;
		logic                           is_last_in;
	} smp_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_out;
		logic                           is_last_out;
	} res_t;

	function automatic logic [HALF_W-1:0] half_of(input win_t w);
		case (w)
			WIN_7:   half_of = HALF_W'(3);
			WIN_9:   half_of = HALF_W'(4);
			default: half_of = HALF_W'(2);
		endcase
	endfunction

	function automatic int div_of(input win_t w);
		case (w)
			WIN_7:   div_of = DIV_7;
			WIN_9:   div_of = DIV_9;
			default: div_of = DIV_5;
		endcase
	endfunction

	function automatic logic [MUL_W-1:0] recip_of(input win_t w);
		case (w)
			WIN_7:   recip_of = MUL_W'(RECIP_7);
			WIN_9:   recip_of = MUL_W'(RECIP_9);
			default: recip_of = MUL_W'(RECIP_5);
		endcase
	endfunction

endpackage

>>> rtl/savitzky_golay_smoother.sv
// quadratic savitzky-golay smoother, 5/7/9-point window selected by the mode written via cfg_we/cfg_wdata
// the first result of a transaction passes the job register, stages s1 to s4 and res_q;
//   the rest of a flush follow one per cycle while res_stall stays low
// throughput: one sample per cycle while res_stall stays low; a last sample stalls the input
//   while the flush walks the delay line
// reset: arst_n clears the pipeline, delay line, sample count and selects 5-point
`include "assert_macros.svh"

module savitzky_golay_smoother (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata,
	input  logic          smp_valid,
	output logic          smp_stall,
	input  sgs_pkg::smp_t smp_item,
	output logic          res_valid,
	input  logic          res_stall,
	output sgs_pkg::res_t res_item
);
	import sgs_pkg::*;

	localparam int W = SAMPLE_WIDTH;

	function automatic logic signed [TERM_W-1:0] wterm(
		input logic signed [W-1:0]      a,
		input logic signed [W-1:0]      b,
		input logic signed [TERM_W-1:0] c
	);
		wterm = (TERM_W'(a) + TERM_W'(b)) * c;
	endfunction

	// front: config, sequence state, delay line, flush job
	logic [1:0]              mode_q;
	win_t                    win_q;
	logic [CNT_W-1:0]        seen_q;
	logic signed [W-1:0]     dl_q [DEPTH];
	logic                    job_v_q;
	logic                    job_last_q;
	logic [HALF_W-1:0]       job_k_q;
	logic [CNT_W-1:0]        job_j_q;

	logic                    smp_acc;
	logic                    job_go;
	logic                    job_final;
	win_t                    win_new;
	logic [HALF_W-1:0]       h_new;
	logic [HALF_W-1:0]       kmax;

	// pipeline
	logic                    v1_q, v2_q, v3_q, v4_q, res_v_q;
	logic                    rdy1, rdy2, rdy3, rdy4, rdy_o;

	logic signed [TERM_W-1:0] term_s1 [5];
	win_t                     win_s1;
	logic                     fixed_s1;
	logic signed [W-1:0]      val_s1;
	logic                     last_s1;

	logic signed [SUM_W-1:0]  sum_s2;
	win_t                     win_s2;
	logic                     fixed_s2;
	logic signed [W-1:0]      val_s2;
	logic                     last_s2;

	logic [A_W-1:0]           a_s3;
	win_t                     win_s3;
	logic                     fixed_s3;
	logic signed [W-1:0]      val_s3;
	logic                     last_s3;

	logic [PROD_W-1:0]        prod_s4;
	win_t                     win_s4;
	logic                     fixed_s4;
	logic signed [W-1:0]      val_s4;
	logic                     last_s4;

	res_t                     res_q;

	// job stage combinational
	logic [HALF_W-1:0]        h_cur;
	logic [CNT_W-1:0]         pos;
	logic                     is_copy;
	logic                     is_kern;
	logic [IDX_W-1:0]         k_idx, up_idx, dn_idx;
	logic signed [W+1:0]      ksum;
	logic signed [W-1:0]      fix_val;
	logic signed [TERM_W-1:0] term_c [5];

	logic signed [SUM_W-1:0]  sum_c;
	logic signed [ACC_W-1:0]  afull;
	logic signed [ACC_W-1:0]  lim;
	logic                     sat_hi, sat_lo;
	logic [W-1:0]             quo;

	assign smp_acc = smp_valid && !smp_stall;

	always_comb begin
		if (seen_q != '0) begin
			win_new = win_q;
		end else if (mode_q == WIN_7) begin
			win_new = WIN_7;
		end else if (mode_q == WIN_9) begin
			win_new = WIN_9;
		end else begin
			win_new = WIN_5;
		end
	end

	assign h_new = half_of(win_new);
	assign kmax  = (seen_q < CNT_W'(h_new)) ? HALF_W'(seen_q) : h_new;

	assign rdy_o = !res_v_q || !res_stall;
	assign rdy4  = !v4_q || rdy_o;
	assign rdy3  = !v3_q || rdy4;
	assign rdy2  = !v2_q || rdy3;
	assign rdy1  = !v1_q || rdy2;

	assign job_go    = job_v_q && rdy1;
	assign job_final = !job_last_q || (job_k_q == '0);
	assign smp_stall = job_v_q && !(job_go && job_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= WIN_5;
			win_q      <= WIN_5;
			seen_q     <= '0;
			job_v_q    <= 1'b0;
			job_last_q <= 1'b0;
			job_k_q    <= '0;
			job_j_q    <= '0;
			for (int n = 0; n < DEPTH; n++) begin
				dl_q[n] <= '0;
			end
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (smp_acc) begin
				win_q   <= win_new;
				dl_q[0] <= smp_item.sample_in;
				for (int n = 1; n < DEPTH; n++) begin
					dl_q[n] <= dl_q[n-1];
				end
				if (smp_item.is_last_in) begin
					seen_q <= '0;
				end else if (seen_q != '1) begin
					seen_q <= seen_q + CNT_W'(1);
				end
				job_v_q    <= smp_item.is_last_in || (seen_q >= CNT_W'(h_new));
				job_last_q <= smp_item.is_last_in;
				job_k_q    <= smp_item.is_last_in ? kmax : h_new;
				job_j_q    <= seen_q;
			end else if (job_go) begin
				if (job_final) begin
					job_v_q <= 1'b0;
				end else begin
					job_k_q <= job_k_q - HALF_W'(1);
				end
			end
		end
	end

	// result selection for the sample at delay position job_k_q
	assign h_cur   = half_of(win_q);
	assign pos     = job_j_q - CNT_W'(job_k_q);
	assign is_copy = (pos == '0) || (job_last_q && job_k_q == '0);
	assign is_kern = (pos < CNT_W'(h_cur)) || (job_last_q && job_k_q < h_cur);
	assign k_idx   = IDX_W'(job_k_q);
	assign up_idx  = k_idx + IDX_W'(1);
	assign dn_idx  = (job_k_q == '0) ? '0 : k_idx - IDX_W'(1);

	assign ksum = (W+2)'(dl_q[up_idx]) + ((W+2)'(dl_q[k_idx]) <<< 1)
		+ (W+2)'(dl_q[dn_idx]) + (W+2)'(2);
	assign fix_val = is_copy ? dl_q[k_idx] : ksum[W+1:2];

	// window always centered on the half-window tap
	always_comb begin
		case (win_q)
			WIN_9: begin
				term_c[0] = wterm(dl_q[4], '0, WT9_0);
				term_c[1] = wterm(dl_q[3], dl_q[5], WT9_1);
				term_c[2] = wterm(dl_q[2], dl_q[6], WT9_2);
				term_c[3] = wterm(dl_q[1], dl_q[7], WT9_3);
				term_c[4] = wterm(dl_q[0], dl_q[8], WT9_4);
			end
			WIN_7: begin
				term_c[0] = wterm(dl_q[3], '0, WT7_0);
				term_c[1] = wterm(dl_q[2], dl_q[4], WT7_1);
				term_c[2] = wterm(dl_q[1], dl_q[5], WT7_2);
				term_c[3] = wterm(dl_q[0], dl_q[6], WT7_3);
				term_c[4] = '0;
			end
			default: begin
				term_c[0] = wterm(dl_q[2], '0, WT5_0);
				term_c[1] = wterm(dl_q[1], dl_q[3], WT5_1);
				term_c[2] = wterm(dl_q[0], dl_q[4], WT5_2);
				term_c[3] = '0;
				term_c[4] = '0;
			end
		endcase
	end

	always_comb begin
		sum_c = '0;
		for (int n = 0; n < 5; n++) begin
			sum_c = sum_c + SUM_W'(term_s1[n]);
		end
	end

	// offset numerator so the quotient is unsigned and below 2**W when in range
	assign afull = (ACC_W'(sum_s2) <<< 1) + ACC_W'(div_of(win_s2))
		+ ACC_W'(2 * div_of(win_s2)) * (ACC_W'(1) <<< (W-1));
	assign lim    = ACC_W'(2 * div_of(win_s2)) * (ACC_W'(1) <<< W);
	assign sat_lo = afull[ACC_W-1];
	assign sat_hi = !sat_lo && (afull >= lim);

	always_comb begin
		case (win_s4)
			WIN_7:   quo = prod_s4[SHIFT_7 +: W];
			WIN_9:   quo = prod_s4[SHIFT_9 +: W];
			default: quo = prod_s4[SHIFT_5 +: W];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= job_v_q;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy_o) begin
				res_v_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_go) begin
			term_s1  <= term_c;
			win_s1   <= win_q;
			fixed_s1 <= is_copy || is_kern;
			val_s1   <= fix_val;
			last_s1  <= job_last_q && (job_k_q == '0);
		end
		if (rdy2 && v1_q) begin
			sum_s2   <= sum_c;
			win_s2   <= win_s1;
			fixed_s2 <= fixed_s1;
			val_s2   <= val_s1;
			last_s2  <= last_s1;
		end
		if (rdy3 && v2_q) begin
			a_s3     <= afull[A_W-1:0];
			win_s3   <= win_s2;
			fixed_s3 <= fixed_s2 || sat_hi || sat_lo;
			val_s3   <= fixed_s2 ? val_s2 : (sat_hi ? SMP_MAX : SMP_MIN);
			last_s3  <= last_s2;
		end
		if (rdy4 && v3_q) begin
			prod_s4  <= PROD_W'(a_s3) * PROD_W'(recip_of(win_s3));
			win_s4   <= win_s3;
			fixed_s4 <= fixed_s3;
			val_s4   <= val_s3;
			last_s4  <= last_s3;
		end
		if (rdy_o && v4_q) begin
			res_q.sample_out  <= fixed_s4 ? val_s4 : {~quo[W-1], quo[W-2:0]};
			res_q.is_last_out <= last_s4;
		end
	end

	assign res_valid = res_v_q;
	assign res_item  = res_q;

	`ASSERT_IMP(a_flush_holds_input, clk, arst_n, job_v_q && job_last_q && (job_k_q != '0), smp_stall)
	`ASSERT_NXT(a_seen_clears_on_last, clk, arst_n, smp_acc && smp_item.is_last_in, seen_q == '0)
	`ASSERT_IMP(a_job_within_half, clk, arst_n, job_v_q, job_k_q <= half_of(win_q))
	`ASSERT_IMP(a_steady_job_centered, clk, arst_n, job_v_q && !job_last_q, job_k_q == half_of(win_q))
	`ASSERT_IMP(a_kernel_has_neighbor, clk, arst_n, job_v_q && is_kern && !is_copy, job_k_q != '0)

endmodule
